// File: rtl/stepper_ramp_homing_controller_core_defines.svh
// Assertion helpers used by the core RTL.
`ifndef STEPPER_RAMP_HOMING_CONTROLLER_CORE_DEFINES_SVH
`define STEPPER_RAMP_HOMING_CONTROLLER_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define SRHC_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("srhc assertion failed");

// Next-cycle implication, disabled in reset.
`define SRHC_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("srhc assertion failed");

`endif

// File: rtl/srhc_pkg.sv
package srhc_pkg;

    localparam int unsigned PERIOD_W = 12;
    localparam int unsigned RAMP_W   = 8;
    localparam int unsigned DEB_W    = 8;
    localparam int unsigned STEPS_W  = 12;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 12;

    typedef logic [1:0] status_t;

    localparam status_t ST_NONE    = 2'd0;
    localparam status_t ST_REACHED = 2'd1;
    localparam status_t ST_TIMEOUT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_INTERVAL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_LIMIT     = 3'd4;

    localparam logic [PERIOD_W-1:0] RST_INITIAL_PERIOD = 12'd1000;
    localparam logic [PERIOD_W-1:0] RST_MIN_PERIOD     = 12'd200;
    localparam logic [RAMP_W-1:0]   RST_RAMP_INTERVAL  = 8'd50;
    localparam logic [DEB_W-1:0]    RST_DEBOUNCE_LIMIT = 8'd100;
    localparam logic [STEPS_W-1:0]  RST_STEP_LIMIT     = 12'd1800;

endpackage

// File: rtl/stepper_ramp_homing_controller_core.sv
// Channel  | ports                                             | handshake
// ---------+---------------------------------------------------+----------------
// input    | s_mode s_direction s_back_stop s_out_stop         | s_valid/s_ready
// result   | m_step_level m_dir_level m_driver_lock m_busy_res | m_valid/m_ready
//          | m_done_res m_status                               |
// config   | cfg_index cfg_wdata                               | cfg_we
//
// One item per cycle unless the output stalls; results are registered on accept.
// The move state is updated at the accepting edge; the result register decouples
// the output side. s_ready is high while the result register is empty or being
// taken, so a stalled output stalls the input. Synchronous active-low reset
// restores register defaults and the idle move state; no clearing pass.

module stepper_ramp_homing_controller_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_mode,
    input  logic                                s_direction,
    input  logic                                s_back_stop,
    input  logic                                s_out_stop,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_step_level,
    output logic                                m_dir_level,
    output logic                                m_driver_lock,
    output logic                                m_busy_res,
    output logic                                m_done_res,
    output logic [1:0]                          m_status,
    input  logic                                cfg_we,
    input  logic [srhc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [srhc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    `include "stepper_ramp_homing_controller_core_defines.svh"

    logic [srhc_pkg::PERIOD_W-1:0] initial_period_reg, min_period_reg;
    logic [srhc_pkg::RAMP_W-1:0]   ramp_interval_reg;
    logic [srhc_pkg::DEB_W-1:0]    debounce_limit_reg;
    logic [srhc_pkg::STEPS_W-1:0]  step_limit_reg;

    logic                          busy_reg, busy_next;
    logic                          dir_reg, dir_next;
    logic                          lock_reg, lock_next;
    logic                          phase_reg, phase_next;
    logic [srhc_pkg::PERIOD_W-1:0] period_reg, period_next;
    logic [srhc_pkg::PERIOD_W-1:0] pcnt_reg, pcnt_next;
    logic [srhc_pkg::RAMP_W-1:0]   rcnt_reg, rcnt_next;
    logic [srhc_pkg::STEPS_W-1:0]  scnt_reg, scnt_next;
    logic [srhc_pkg::DEB_W-1:0]    stable_reg, stable_next;
    logic                          done_next;
    srhc_pkg::status_t             status_next;

    logic                          m_valid_reg;
    logic                          m_done_reg;
    srhc_pkg::status_t             m_status_reg;
    logic                          m_step_reg, m_dir_reg, m_lock_reg, m_busy_reg;

    logic accept;
    logic start_stop;
    logic move_stop;
    logic timed_out;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            initial_period_reg <= srhc_pkg::RST_INITIAL_PERIOD;
            min_period_reg     <= srhc_pkg::RST_MIN_PERIOD;
            ramp_interval_reg  <= srhc_pkg::RST_RAMP_INTERVAL;
            debounce_limit_reg <= srhc_pkg::RST_DEBOUNCE_LIMIT;
            step_limit_reg     <= srhc_pkg::RST_STEP_LIMIT;
        end else if (cfg_we) begin
            unique case (cfg_index)
                srhc_pkg::REG_INITIAL_PERIOD: initial_period_reg <= cfg_wdata;
                srhc_pkg::REG_MIN_PERIOD:     min_period_reg     <= cfg_wdata;
                srhc_pkg::REG_RAMP_INTERVAL:
                    ramp_interval_reg  <= cfg_wdata[srhc_pkg::RAMP_W-1:0];
                srhc_pkg::REG_DEBOUNCE_LIMIT:
                    debounce_limit_reg <= cfg_wdata[srhc_pkg::DEB_W-1:0];
                srhc_pkg::REG_STEP_LIMIT:     step_limit_reg     <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign start_stop = s_direction ? s_out_stop : s_back_stop;
    assign move_stop  = dir_reg ? s_out_stop : s_back_stop;

    always_comb begin
        busy_next   = busy_reg;
        dir_next    = dir_reg;
        lock_next   = lock_reg;
        phase_next  = phase_reg;
        period_next = period_reg;
        pcnt_next   = pcnt_reg;
        rcnt_next   = rcnt_reg;
        scnt_next   = scnt_reg;
        stable_next = stable_reg;
        done_next   = 1'b0;
        status_next = srhc_pkg::ST_NONE;
        timed_out   = 1'b0;
        if (s_mode) begin
            period_next = initial_period_reg;
            if (start_stop) begin
                busy_next   = 1'b0;
                lock_next   = 1'b1;
                done_next   = 1'b1;
                status_next = srhc_pkg::ST_REACHED;
            end else begin
                dir_next    = s_direction;
                busy_next   = 1'b1;
                lock_next   = 1'b0;
                pcnt_next   = '0;
                rcnt_next   = '0;
                scnt_next   = '0;
                stable_next = '0;
            end
        end else if (busy_reg) begin
            if (pcnt_reg < period_reg) begin
                pcnt_next = pcnt_reg + 1'b1;
            end else begin
                pcnt_next  = '0;
                phase_next = !phase_reg;
                if (scnt_reg < step_limit_reg) begin
                    scnt_next = scnt_reg + 1'b1;
                end else begin
                    timed_out = 1'b1;
                end
            end
            if (timed_out) begin
                busy_next   = 1'b0;
                lock_next   = 1'b1;
                done_next   = 1'b1;
                status_next = srhc_pkg::ST_TIMEOUT;
            end else if (rcnt_reg < ramp_interval_reg) begin
                rcnt_next = rcnt_reg + 1'b1;
            end else begin
                rcnt_next = '0;
                if (period_reg > min_period_reg) begin
                    period_next = period_reg - 1'b1;
                end
                if (!move_stop) begin
                    stable_next = '0;
                end else if (stable_reg < debounce_limit_reg) begin
                    stable_next = stable_reg + 1'b1;
                end else begin
                    busy_next   = 1'b0;
                    lock_next   = 1'b1;
                    done_next   = 1'b1;
                    status_next = srhc_pkg::ST_REACHED;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            dir_reg    <= 1'b1;
            lock_reg   <= 1'b1;
            phase_reg  <= 1'b0;
            period_reg <= srhc_pkg::RST_INITIAL_PERIOD;
            pcnt_reg   <= '0;
            rcnt_reg   <= '0;
            scnt_reg   <= '0;
            stable_reg <= '0;
        end else if (accept) begin
            busy_reg   <= busy_next;
            dir_reg    <= dir_next;
            lock_reg   <= lock_next;
            phase_reg  <= phase_next;
            period_reg <= period_next;
            pcnt_reg   <= pcnt_next;
            rcnt_reg   <= rcnt_next;
            scnt_reg   <= scnt_next;
            stable_reg <= stable_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_step_reg   <= !phase_next;
            m_dir_reg    <= dir_next;
            m_lock_reg   <= lock_next;
            m_busy_reg   <= busy_next;
            m_done_reg   <= done_next;
            m_status_reg <= status_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_step_level  = m_step_reg;
    assign m_dir_level   = m_dir_reg;
    assign m_driver_lock = m_lock_reg;
    assign m_busy_res    = m_busy_reg;
    assign m_done_res    = m_done_reg;
    assign m_status      = m_status_reg;

    `SRHC_ASSERT_IMP(a_busy_unlocked, aclk, aresetn, busy_reg, !lock_reg)
    `SRHC_ASSERT_NXT(a_accept_fills, aclk, aresetn, accept, m_valid_reg)
    `SRHC_ASSERT_NXT(a_start_runs, aclk, aresetn, accept && s_mode && !start_stop, busy_reg)
    `SRHC_ASSERT_IMP(a_done_result, aclk, aresetn, m_valid_reg && m_done_reg,
        !m_busy_reg && m_lock_reg && (m_status_reg != srhc_pkg::ST_NONE))

endmodule
